// File: rtl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// Depends on nothing; imported by every other file of the block.
package fbpa_pkg;

  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned IdxW     = $clog2(MaxSlots);
  localparam int unsigned LinkW    = IdxW + 1;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned DivSteps = AddrW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned ProdW    = IdxW + SizeW;

  typedef enum logic [1:0] {
    CMD_GET      = 2'd0,
    CMD_PUT      = 2'd1,
    CMD_INDEX    = 2'd2,
    CMD_RETHREAD = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_EMPTY      = 3'd1,
    STS_BAD_PUT    = 3'd2,
    STS_BAD_INDEX  = 3'd3,
    STS_BAD_SIZE   = 3'd4,
    STS_ZERO_SLOTS = 3'd5,
    STS_NULL       = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_POOL_BYTES  = 2'd1,
    REG_OBJECT_SIZE = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GET,
    S_DIV,
    S_SWEEP,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic get_apply;
    logic resolve;
    logic sweep;
    logic publish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pc_final;
    logic pc_div;
    logic div_done;
    logic need_sweep;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/fbpa_div.sv
// Restoring divider, one quotient bit per cycle (32-bit dividend, 16-bit divisor).
// Depends on fbpa_pkg.
module fbpa_div
  import fbpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AddrW-1:0] dividend_i,
  input  logic [SizeW-1:0] divisor_i,
  output logic             done_o,
  output logic [AddrW-1:0] quot_o,
  output logic [SizeW-1:0] rem_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [AddrW-1:0]   quo_q;
  logic [SizeW-1:0]   rem_q;

  logic [SizeW:0]     trial;
  logic [SizeW:0]     diff;
  logic               fits;
  logic [SizeW-1:0]   rem_next;

  always_comb begin
    trial    = {rem_q, quo_q[AddrW-1]};
    diff     = trial - {1'b0, divisor_i};
    fits     = trial >= {1'b0, divisor_i};
    rem_next = fits ? diff[SizeW-1:0] : trial[SizeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= DivCntW'(DivSteps - 1);
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      quo_q <= {quo_q[AddrW-2:0], fits};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/fbpa_dp.sv
// Allocator datapath: config registers, free-list head, link memory, divider, result registers.
// Depends on fbpa_pkg and fbpa_div.
module fbpa_dp
  import fbpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  // item payload
  input  logic [1:0]        cmd_in_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [2:0]        status_o,
  output logic [AddrW-1:0]  addr_out_o,
  output logic [IdxW-1:0]   index_out_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata
);

  // config
  logic [AddrW-1:0] pool_base_q;
  logic [AddrW-1:0] pool_bytes_q;
  logic [SizeW-1:0] object_size_q;
  reg_e             reg_sel;
  logic             cfg_we;

  // list state
  logic [LinkW-1:0] free_head_q, free_head_d;
  logic [LinkW-1:0] slot_count_q, slot_count_d;
  logic [LinkW-1:0] link_mem [MaxSlots];
  logic [LinkW-1:0] rd_q;

  // item and work registers
  cmd_e             cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [ProdW-1:0] prod_q;
  logic [IdxW-1:0]  sweep_q, sweep_d;

  status_e          stg_status_q, stg_status_d;
  logic [AddrW-1:0] stg_addr_q, stg_addr_d;
  logic [IdxW-1:0]  stg_index_q, stg_index_d;

  status_e          out_status_q;
  logic [AddrW-1:0] out_addr_q;
  logic [IdxW-1:0]  out_index_q;
  logic             out_valid_q;

  // checks
  logic             size_ok;
  logic             in_region;
  logic [AddrW:0]   region_end;
  logic [AddrW-1:0] offset;
  logic             empty;
  logic             pc_final;
  logic             pc_div;
  status_e          pc_status;

  // divider
  logic             div_start;
  logic [AddrW-1:0] div_dividend;
  logic             div_done;
  logic [AddrW-1:0] quot;
  logic [SizeW-1:0] rem;
  logic             q_big;
  logic [LinkW-1:0] count;

  // memory write
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [LinkW-1:0] mem_wdata;
  logic [LinkW-1:0] sweep_next;
  logic             sweep_last;
  logic             put_ok;

  // ---------------- register port ----------------
  assign reg_sel = reg_e'(paddr[PaddrW-1:2]);
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      pool_bytes_q  <= '0;
      object_size_q <= SizeW'(8);
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_POOL_BASE:   pool_base_q   <= pwdata;
        REG_POOL_BYTES:  pool_bytes_q  <= pwdata;
        REG_OBJECT_SIZE: object_size_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POOL_BASE:   prdata = pool_base_q;
      REG_POOL_BYTES:  prdata = pool_bytes_q;
      REG_OBJECT_SIZE: prdata = DataW'(object_size_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- pre-checks ----------------
  always_comb begin
    size_ok    = (object_size_q >= SizeW'(8)) && (object_size_q[2:0] == 3'd0);
    region_end = {1'b0, pool_base_q} + {1'b0, pool_bytes_q};
    in_region  = (addr_q >= pool_base_q) && ({1'b0, addr_q} < region_end);
    offset     = addr_q - pool_base_q;
    empty      = (free_head_q >= slot_count_q) || (free_head_q >= LinkW'(MaxSlots));
  end

  always_comb begin
    pc_final  = 1'b0;
    pc_div    = 1'b0;
    pc_status = STS_OK;
    unique case (cmd_q)
      CMD_GET: begin
        if (empty) begin
          pc_final  = 1'b1;
          pc_status = STS_EMPTY;
        end
      end
      CMD_PUT, CMD_INDEX: begin
        if (addr_q == '0) begin
          pc_final  = 1'b1;
          pc_status = STS_NULL;
        end else if (!size_ok) begin
          pc_final  = 1'b1;
          pc_status = STS_BAD_SIZE;
        end else if (!in_region) begin
          pc_final  = 1'b1;
          pc_status = (cmd_q == CMD_PUT) ? STS_BAD_PUT : STS_BAD_INDEX;
        end else begin
          pc_div = 1'b1;
        end
      end
      CMD_RETHREAD: begin
        if (pool_base_q == '0) begin
          pc_final  = 1'b1;
          pc_status = STS_NULL;
        end else if (!size_ok) begin
          pc_final  = 1'b1;
          pc_status = STS_BAD_SIZE;
        end else begin
          pc_div = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- divider ----------------
  assign div_start    = cmd_i.check & pc_div;
  assign div_dividend = (cmd_q == CMD_RETHREAD) ? pool_bytes_q : offset;

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (object_size_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign q_big  = quot >= AddrW'(MaxSlots);
  assign count  = q_big ? LinkW'(MaxSlots) : quot[LinkW-1:0];
  assign put_ok = (rem == '0) && !q_big && (quot < AddrW'(slot_count_q));

  // ---------------- link sweep and memory ----------------
  assign sweep_next = {1'b0, sweep_q} + 1'b1;
  assign sweep_last = sweep_next == slot_count_q;

  always_comb begin
    mem_we    = cmd_i.sweep || (cmd_i.resolve && cmd_q == CMD_PUT && put_ok);
    mem_waddr = cmd_i.sweep ? sweep_q : quot[IdxW-1:0];
    if (cmd_i.sweep) begin
      mem_wdata = sweep_last ? LinkW'(MaxSlots) : sweep_next;
    end else begin
      mem_wdata = free_head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.check) begin
      rd_q   <= link_mem[free_head_q[IdxW-1:0]];
      prod_q <= ProdW'(free_head_q[IdxW-1:0]) * ProdW'(object_size_q);
    end
  end

  // ---------------- next-state of list and staging ----------------
  always_comb begin
    free_head_d  = free_head_q;
    slot_count_d = slot_count_q;
    sweep_d      = sweep_q;
    stg_status_d = stg_status_q;
    stg_addr_d   = stg_addr_q;
    stg_index_d  = stg_index_q;

    if (cmd_i.check) begin
      stg_status_d = pc_status;
      stg_addr_d   = '0;
      stg_index_d  = '0;
    end

    if (cmd_i.get_apply) begin
      stg_addr_d  = pool_base_q + AddrW'(prod_q);
      free_head_d = rd_q;
    end

    if (cmd_i.resolve) begin
      unique case (cmd_q)
        CMD_PUT: begin
          if (put_ok) begin
            free_head_d = {1'b0, quot[IdxW-1:0]};
          end else begin
            stg_status_d = STS_BAD_PUT;
          end
        end
        CMD_INDEX: begin
          if ((rem != '0) || q_big) begin
            stg_status_d = STS_BAD_INDEX;
          end else begin
            stg_index_d = quot[IdxW-1:0];
          end
        end
        CMD_RETHREAD: begin
          slot_count_d = count;
          sweep_d      = '0;
          if (count == '0) begin
            free_head_d  = LinkW'(MaxSlots);
            stg_status_d = STS_ZERO_SLOTS;
          end else begin
            free_head_d = '0;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.sweep) begin
      sweep_d = sweep_next[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= LinkW'(MaxSlots);
      slot_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      free_head_q  <= free_head_d;
      slot_count_q <= slot_count_d;
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_e'(cmd_in_i);
      addr_q <= addr_i;
    end
    sweep_q      <= sweep_d;
    stg_status_q <= stg_status_d;
    stg_addr_q   <= stg_addr_d;
    stg_index_q  <= stg_index_d;
    if (cmd_i.publish) begin
      out_status_q <= stg_status_q;
      out_addr_q   <= stg_addr_q;
      out_index_q  <= stg_index_q;
    end
  end

  // ---------------- status to controller, outputs ----------------
  always_comb begin
    sts_o.pc_final   = pc_final;
    sts_o.pc_div     = pc_div;
    sts_o.div_done   = div_done;
    sts_o.need_sweep = (cmd_q == CMD_RETHREAD) && (count != '0);
    sts_o.sweep_last = sweep_last;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign addr_out_o  = out_addr_q;
  assign index_out_o = out_index_q;

endmodule

// File: rtl/fbpa_ctrl.sv
// Allocator controller: sequences capture, checks, get, divide, link sweep and result hand-off.
// Depends on fbpa_pkg.
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        priority if (sts_i.pc_final) begin
          state_d = S_DONE;
        end else if (sts_i.pc_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_GET;
        end
      end
      S_GET: begin
        cmd_o.get_apply = 1'b1;
        state_d         = S_DONE;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.resolve = 1'b1;
          state_d       = sts_i.need_sweep ? S_SWEEP : S_DONE;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: controller plus datapath, APB config port.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp (and fbpa_div below it).
//
// Hands out equal-size slots of one memory region (pool_base, pool_bytes,
// object_size) from a LIFO free list of up to 1024 slots; every command
// transfer gives exactly one result transfer. One command is worked at a time;
// a new command is taken while the previous result still waits in the output
// register. Steps from command transfer to result: get does a head lookup
// in the link memory (one read port) plus the slot multiply; put and
// index-of run through the shared restoring divider that makes one quotient
// bit per cycle (32 steps); rethread uses the divider and then threads the
// link memory one entry per cycle (up to 1024 entries). Commands rejected by
// the up-front checks (null address, bad size, outside the region, empty
// list) skip the divider and go straight to the result. The link memory has
// no clearing pass after reset; an entry's value is only used after a
// rethread or put has written it. Registers: pool_base at 0x0, pool_bytes
// at 0x4, object_size at 0x8 (low 16 bits); write them only while idle.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [AddrW-1:0]  addr_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [AddrW-1:0]  addr_out_o,
  output logic [IdxW-1:0]   index_out_o,
  // APB config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // zero-wait-state register port
  assign pready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  fbpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .cmd_in_i    (cmd_i),
    .addr_i      (addr_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .addr_out_o  (addr_out_o),
    .index_out_o (index_out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule
